[hdl/lpht_pkg.sv]
// lpht_pkg: sizes, operation codes and status codes for the hash table
// no dependencies; imported by linear_probe_hash_table (lpht_ram does not use it)

package lpht_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = IDX_W + 1;
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 64;
  localparam int LIM_W    = 6;
  localparam int OCC_W    = 7;

  localparam logic [LIM_W-1:0] MAX_ENTRIES_RST = LIM_W'(48);

  localparam logic [1:0] KIND_SET = 2'd0;
  localparam logic [1:0] KIND_GET = 2'd1;
  localparam logic [1:0] KIND_DEL = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;

endpackage

[hdl/lpht_ram.sv]
// lpht_ram: simple dual-port synchronous ram, one write and one read port
// registered read data; no package dependency

module lpht_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/linear_probe_hash_table.sv]
// linear_probe_hash_table: open-addressing map with linear probing and tombstones
// depends on lpht_pkg and lpht_ram (key and value store)
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-----------------------------------------
//  command   | start, busy               | kind_i, key_id_i, key_hash_i, value_in_i
//  result    | done_o (one-cycle strobe) | status_o, is_new_o, value_out_o
//  config    | max_entries_we_i          | max_entries_i
//
// an item runs from start through the probe to the finish state, which raises the
// done strobe; the probe steps past tombstone slots and stops on an empty slot or
// a matching key; each used slot costs a ram read then a key compare
// the probe visits at most 64 slots; kind 3 goes straight to the finish state
// the next item can start in the cycle the done strobe is shown
// reset empties the table at once (valid and tombstone bits in flops), limit 48
// the receiver cannot stall: the result is shown for exactly one cycle

module linear_probe_hash_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  kind_i,
  input  logic [lpht_pkg::KEY_W-1:0]  key_id_i,
  input  logic [31:0]                 key_hash_i,
  input  logic [lpht_pkg::VAL_W-1:0]  value_in_i,
  output logic                        done_o,
  output logic [1:0]                  status_o,
  output logic                        is_new_o,
  output logic [lpht_pkg::VAL_W-1:0]  value_out_o,
  input  logic                        max_entries_we_i,
  input  logic [lpht_pkg::LIM_W-1:0]  max_entries_i
);

  import lpht_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_PROBE  = 2'd1;
  localparam logic [1:0] ST_CMP    = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [1:0]       kind_q, kind_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             hit_q, hit_d;
  logic             empty_q, empty_d;
  logic             have_tomb_q, have_tomb_d;
  logic [IDX_W-1:0] tomb_idx_q, tomb_idx_d;

  logic [CAPACITY-1:0] used_q, used_d;
  logic [CAPACITY-1:0] tomb_q, tomb_d;
  logic [OCC_W-1:0]    occ_q, occ_d;
  logic [LIM_W-1:0]    max_q;

  logic             done_q, done_d;
  logic [1:0]       status_q, status_d;
  logic             is_new_q, is_new_d;
  logic [VAL_W-1:0] vout_q, vout_d;

  logic                   ram_we, ram_re;
  logic [IDX_W-1:0]       ram_waddr;
  logic [KEY_W+VAL_W-1:0] ram_rdata;
  logic [KEY_W-1:0]       rd_key;
  logic [VAL_W-1:0]       rd_val;

  assign rd_key = ram_rdata[KEY_W+VAL_W-1:VAL_W];
  assign rd_val = ram_rdata[VAL_W-1:0];

  lpht_ram #(
    .WIDTH (KEY_W + VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({key_q, val_q}),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    key_d       = key_q;
    val_d       = val_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    hit_d       = hit_q;
    empty_d     = empty_q;
    have_tomb_d = have_tomb_q;
    tomb_idx_d  = tomb_idx_q;
    used_d      = used_q;
    tomb_d      = tomb_q;
    occ_d       = occ_q;
    done_d      = 1'b0;
    status_d    = status_q;
    is_new_d    = is_new_q;
    vout_d      = vout_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = idx_q;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          kind_d      = kind_i;
          key_d       = key_id_i;
          val_d       = value_in_i;
          idx_d       = key_hash_i[IDX_W-1:0];
          cnt_d       = '0;
          hit_d       = 1'b0;
          empty_d     = 1'b0;
          have_tomb_d = 1'b0;
          tomb_idx_d  = '0;
          state_d     = (kind_i inside {KIND_SET, KIND_GET, KIND_DEL}) ? ST_PROBE : ST_FINISH;
        end
      end
      ST_PROBE: begin
        if (cnt_q == CNT_W'(CAPACITY)) begin
          state_d = ST_FINISH;
        end else if (used_q[idx_q]) begin
          ram_re  = 1'b1;
          state_d = ST_CMP;
        end else if (tomb_q[idx_q]) begin
          if (!have_tomb_q) begin
            have_tomb_d = 1'b1;
            tomb_idx_d  = idx_q;
          end
          idx_d = idx_q + 1'b1;
          cnt_d = cnt_q + 1'b1;
        end else begin
          empty_d = 1'b1;
          state_d = ST_FINISH;
        end
      end
      ST_CMP: begin
        if (rd_key == key_q) begin
          hit_d   = 1'b1;
          state_d = ST_FINISH;
        end else begin
          idx_d   = idx_q + 1'b1;
          cnt_d   = cnt_q + 1'b1;
          state_d = ST_PROBE;
        end
      end
      ST_FINISH: begin
        done_d   = 1'b1;
        status_d = STATUS_NOT_FOUND;
        is_new_d = 1'b0;
        vout_d   = '0;
        state_d  = ST_IDLE;
        case (kind_q)
          KIND_SET: begin
            if (hit_q) begin
              ram_we   = 1'b1;
              status_d = STATUS_OK;
            end else if (have_tomb_q) begin
              ram_we             = 1'b1;
              ram_waddr          = tomb_idx_q;
              used_d[tomb_idx_q] = 1'b1;
              tomb_d[tomb_idx_q] = 1'b0;
              status_d           = STATUS_OK;
              is_new_d           = 1'b1;
            end else if (empty_q && (occ_q < {1'b0, max_q})) begin
              ram_we        = 1'b1;
              used_d[idx_q] = 1'b1;
              occ_d         = occ_q + 1'b1;
              status_d      = STATUS_OK;
              is_new_d      = 1'b1;
            end else begin
              status_d = STATUS_FULL;
            end
          end
          KIND_GET: begin
            if (hit_q) begin
              status_d = STATUS_OK;
              vout_d   = rd_val;
            end
          end
          KIND_DEL: begin
            if (hit_q) begin
              used_d[idx_q] = 1'b0;
              tomb_d[idx_q] = 1'b1;
              status_d      = STATUS_OK;
            end
          end
          default: begin
            status_d = STATUS_NOT_FOUND;
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      used_q  <= '0;
      tomb_q  <= '0;
      occ_q   <= '0;
      max_q   <= MAX_ENTRIES_RST;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      tomb_q  <= tomb_d;
      occ_q   <= occ_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
      if (max_entries_we_i) begin
        max_q <= max_entries_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    key_q       <= key_d;
    val_q       <= val_d;
    idx_q       <= idx_d;
    hit_q       <= hit_d;
    empty_q     <= empty_d;
    have_tomb_q <= have_tomb_d;
    tomb_idx_q  <= tomb_idx_d;
    status_q    <= status_d;
    is_new_q    <= is_new_d;
    vout_q      <= vout_d;
  end

  assign busy        = (state_q != ST_IDLE);
  assign done_o      = done_q;
  assign status_o    = status_q;
  assign is_new_o    = is_new_q;
  assign value_out_o = vout_q;

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while still busy");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  a_used_tomb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q & tomb_q) == '0)
    else $error("slot marked both used and tombstone");

  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("probe count past capacity");

  a_occ_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q != $past(occ_q)) |-> (done_o && is_new_o && (occ_q == $past(occ_q) + 1'b1)))
    else $error("occupancy changed without a new insert");
`endif

endmodule
